### hw/rtl/hrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrp_pkg;

    // Sizing of the offset counter and the version accumulators
    localparam int OFFSET_BITS  = 16;
    localparam int VERSION_BITS = 8;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    // Characters the parser looks for
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Method words, first letter in the top byte
    localparam logic [23:0] WORD_GET  = 24'h474554;
    localparam logic [31:0] WORD_POST = 32'h504F5354;
    localparam logic [31:0] WORD_HEAD = 32'h48454144;

    // Event kinds
    localparam logic [2:0] EV_LINE        = 3'd0;
    localparam logic [2:0] EV_HEADER      = 3'd1;
    localparam logic [2:0] EV_END         = 3'd2;
    localparam logic [2:0] EV_BAD_METHOD  = 3'd3;
    localparam logic [2:0] EV_BAD_REQUEST = 3'd4;
    localparam logic [2:0] EV_BAD_HEADER  = 3'd5;

    // Method codes
    localparam logic [1:0] METH_UNKNOWN = 2'd0;
    localparam logic [1:0] METH_GET     = 2'd1;
    localparam logic [1:0] METH_HEAD    = 2'd2;
    localparam logic [1:0] METH_POST    = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [1:0]  method_code;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
        logic [15:0] first_span_start;
        logic [15:0] first_span_end;
        logic [15:0] second_span_start;
        logic [15:0] second_span_end;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_RL_START, ST_METHOD, ST_SP_URI, ST_URI, ST_PROTO, ST_P_H, ST_P_HT,
        ST_P_HTT, ST_P_HTTP, ST_MAJ_FIRST, ST_MAJ, ST_MIN_FIRST, ST_MIN,
        ST_SP_END, ST_RL_CR, ST_HD_START, ST_KEY, ST_SP_COLON, ST_SP_VALUE,
        ST_VALUE, ST_HD_CR, ST_HD_CRLF, ST_HD_CRLFCR
    } t_state;

    // Whole parser context, carried between the top level and the step logic
    typedef struct packed {
        t_state                        state;
        logic                          halted;
        logic [OFFSET_BITS-1:0]        offset;
        logic [31:0]                   method_bytes;
        logic [3:0][OFFSET_BITS-1:0]   spans;
        logic [VERSION_BITS-1:0]       major;
        logic [VERSION_BITS-1:0]       minor;
        logic [1:0]                    method_found;
    } t_parse_regs;

    localparam t_parse_regs REGS_RESET = '{state: ST_RL_START, default: '0};

endpackage

`default_nettype wire

### hw/rtl/hrp_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One parser step: context and byte in, next context and optional event out.
module hrp_step (
    input  wire hrp_pkg::t_parse_regs i_cur,
    input  wire hrp_pkg::t_in_item    i_item,
    output hrp_pkg::t_parse_regs      o_nxt,
    output logic                      o_ev_valid,
    output hrp_pkg::t_out_item        o_ev
);

    localparam int OB = hrp_pkg::OFFSET_BITS;
    localparam int VB = hrp_pkg::VERSION_BITS;

    function automatic logic is_method_char(input logic [7:0] c);
        return (c >= hrp_pkg::CH_A && c <= hrp_pkg::CH_Z) || c == hrp_pkg::CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= hrp_pkg::CH_ZERO && c <= hrp_pkg::CH_NINE;
    endfunction

    // v * 10 + digit, saturating
    function automatic logic [VB-1:0] version_acc(input logic [VB-1:0] v,
                                                  input logic [7:0] c);
        logic [VB+3:0] n;
        n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{VB{1'b0}}, c[3:0]};
        if (n[VB+3:VB] != 4'b0000) begin
            return {VB{1'b1}};
        end
        return n[VB-1:0];
    endfunction

    function automatic logic [15:0] span_out(input logic [OB-1:0] v);
        logic [OB+15:0] e;
        e = {16'b0, v};
        return e[15:0];
    endfunction

    function automatic logic [7:0] ver_out(input logic [VB-1:0] v);
        logic [VB+7:0] e;
        e = {8'b0, v};
        return e[7:0];
    endfunction

    function automatic logic [1:0] classify(input logic [OB-1:0] len,
                                            input logic [31:0] mb);
        if (len == OB'(3) && mb[23:0] == hrp_pkg::WORD_GET) return hrp_pkg::METH_GET;
        if (len == OB'(4) && mb == hrp_pkg::WORD_POST) return hrp_pkg::METH_POST;
        if (len == OB'(4) && mb == hrp_pkg::WORD_HEAD) return hrp_pkg::METH_HEAD;
        return hrp_pkg::METH_UNKNOWN;
    endfunction

    hrp_pkg::t_parse_regs cur;
    logic [7:0]           c;
    logic [OB-1:0]        pos;
    logic                 ev_fail;
    logic [2:0]           fail_kind;
    logic                 ev_line;
    logic                 ev_hdr;
    logic                 ev_end;

    // restart clears the context before the byte is handled
    assign cur = i_item.restart ? hrp_pkg::REGS_RESET : i_cur;
    assign c   = i_item.data_byte;
    assign pos = cur.offset;

    // Event decode
    always_comb begin
        ev_fail   = 1'b0;
        fail_kind = hrp_pkg::EV_BAD_REQUEST;
        ev_line   = 1'b0;
        ev_hdr    = 1'b0;
        ev_end    = 1'b0;
        if (!cur.halted) begin
            unique case (cur.state)
                hrp_pkg::ST_RL_START: begin
                    if (c != hrp_pkg::CH_CR && c != hrp_pkg::CH_LF && !is_method_char(c)) begin
                        ev_fail   = 1'b1;
                        fail_kind = hrp_pkg::EV_BAD_METHOD;
                    end
                end
                hrp_pkg::ST_METHOD: begin
                    if (c != hrp_pkg::CH_SP && !is_method_char(c)) begin
                        ev_fail   = 1'b1;
                        fail_kind = hrp_pkg::EV_BAD_METHOD;
                    end
                end
                hrp_pkg::ST_SP_URI:
                    ev_fail = c != hrp_pkg::CH_SLASH && c != hrp_pkg::CH_SP;
                hrp_pkg::ST_URI: ;
                hrp_pkg::ST_PROTO:
                    ev_fail = c != hrp_pkg::CH_SP && c != hrp_pkg::CH_H;
                hrp_pkg::ST_P_H:      ev_fail = c != hrp_pkg::CH_T;
                hrp_pkg::ST_P_HT:     ev_fail = c != hrp_pkg::CH_T;
                hrp_pkg::ST_P_HTT:    ev_fail = c != hrp_pkg::CH_P;
                hrp_pkg::ST_P_HTTP:   ev_fail = c != hrp_pkg::CH_SLASH;
                hrp_pkg::ST_MAJ_FIRST:
                    ev_fail = c < hrp_pkg::CH_ONE || c > hrp_pkg::CH_NINE;
                hrp_pkg::ST_MAJ:
                    ev_fail = c != hrp_pkg::CH_DOT && !is_digit(c);
                hrp_pkg::ST_MIN_FIRST: ev_fail = !is_digit(c);
                hrp_pkg::ST_MIN, hrp_pkg::ST_SP_END: begin
                    if (c == hrp_pkg::CH_LF) begin
                        ev_line = 1'b1;
                    end else if (c != hrp_pkg::CH_CR && c != hrp_pkg::CH_SP) begin
                        ev_fail = cur.state == hrp_pkg::ST_SP_END || !is_digit(c);
                    end
                end
                hrp_pkg::ST_RL_CR: begin
                    ev_fail = c != hrp_pkg::CH_LF;
                    ev_line = c == hrp_pkg::CH_LF;
                end
                hrp_pkg::ST_HD_START, hrp_pkg::ST_KEY, hrp_pkg::ST_SP_VALUE,
                hrp_pkg::ST_HD_CRLF: ;
                hrp_pkg::ST_SP_COLON: begin
                    ev_fail   = c != hrp_pkg::CH_COLON && c != hrp_pkg::CH_SP;
                    fail_kind = hrp_pkg::EV_BAD_HEADER;
                end
                hrp_pkg::ST_VALUE: ev_hdr = c == hrp_pkg::CH_LF;
                hrp_pkg::ST_HD_CR: begin
                    ev_fail   = c != hrp_pkg::CH_LF;
                    fail_kind = hrp_pkg::EV_BAD_HEADER;
                    ev_hdr    = c == hrp_pkg::CH_LF;
                end
                hrp_pkg::ST_HD_CRLFCR: begin
                    ev_fail   = c != hrp_pkg::CH_LF;
                    fail_kind = hrp_pkg::EV_BAD_HEADER;
                    ev_end    = c == hrp_pkg::CH_LF;
                end
                default: ;
            endcase
        end
    end

    // Event fields; anything that does not belong to the event stays zero
    always_comb begin
        o_ev       = '0;
        o_ev_valid = ev_fail || ev_line || ev_hdr || ev_end;
        if (ev_fail) begin
            o_ev.event_kind = fail_kind;
        end else if (ev_end) begin
            o_ev.event_kind = hrp_pkg::EV_END;
        end else if (ev_line || ev_hdr) begin
            o_ev.event_kind        = ev_line ? hrp_pkg::EV_LINE : hrp_pkg::EV_HEADER;
            o_ev.first_span_start  = span_out(cur.spans[0]);
            o_ev.first_span_end    = span_out(cur.spans[1]);
            o_ev.second_span_start = span_out(cur.spans[2]);
            // bare LF after a value marks the value end in the same byte
            o_ev.second_span_end   = (cur.state == hrp_pkg::ST_VALUE) ?
                                     span_out(pos) : span_out(cur.spans[3]);
            if (ev_line) begin
                o_ev.method_code   = cur.method_found;
                o_ev.version_major = ver_out(cur.major);
                o_ev.version_minor = ver_out(cur.minor);
            end
        end
    end

    // Next context
    always_comb begin
        o_nxt = cur;
        if (!cur.halted) begin
            if (cur.offset != hrp_pkg::OFFSET_MAX) begin
                o_nxt.offset = cur.offset + OB'(1);
            end
            if (ev_fail) begin
                o_nxt.halted = 1'b1;
            end else begin
                unique case (cur.state)
                    hrp_pkg::ST_RL_START: begin
                        if (c != hrp_pkg::CH_CR && c != hrp_pkg::CH_LF) begin
                            o_nxt.spans[0]     = pos;
                            o_nxt.method_bytes = {24'b0, c};
                            o_nxt.state        = hrp_pkg::ST_METHOD;
                        end
                    end
                    hrp_pkg::ST_METHOD: begin
                        if (c == hrp_pkg::CH_SP) begin
                            o_nxt.spans[1]     = pos;
                            o_nxt.method_found = classify(pos - cur.spans[0],
                                                          cur.method_bytes);
                            o_nxt.state        = hrp_pkg::ST_SP_URI;
                        end else begin
                            o_nxt.method_bytes = {cur.method_bytes[23:0], c};
                        end
                    end
                    hrp_pkg::ST_SP_URI: begin
                        if (c == hrp_pkg::CH_SLASH) begin
                            o_nxt.spans[2] = pos;
                            o_nxt.state    = hrp_pkg::ST_URI;
                        end
                    end
                    hrp_pkg::ST_URI: begin
                        if (c == hrp_pkg::CH_SP) begin
                            o_nxt.spans[3] = pos;
                            o_nxt.state    = hrp_pkg::ST_PROTO;
                        end
                    end
                    hrp_pkg::ST_PROTO: begin
                        if (c == hrp_pkg::CH_H) o_nxt.state = hrp_pkg::ST_P_H;
                    end
                    hrp_pkg::ST_P_H:    o_nxt.state = hrp_pkg::ST_P_HT;
                    hrp_pkg::ST_P_HT:   o_nxt.state = hrp_pkg::ST_P_HTT;
                    hrp_pkg::ST_P_HTT:  o_nxt.state = hrp_pkg::ST_P_HTTP;
                    hrp_pkg::ST_P_HTTP: o_nxt.state = hrp_pkg::ST_MAJ_FIRST;
                    hrp_pkg::ST_MAJ_FIRST: begin
                        o_nxt.major = version_acc('0, c);
                        o_nxt.state = hrp_pkg::ST_MAJ;
                    end
                    hrp_pkg::ST_MAJ: begin
                        if (c == hrp_pkg::CH_DOT) begin
                            o_nxt.state = hrp_pkg::ST_MIN_FIRST;
                        end else begin
                            o_nxt.major = version_acc(cur.major, c);
                        end
                    end
                    hrp_pkg::ST_MIN_FIRST: begin
                        o_nxt.minor = version_acc('0, c);
                        o_nxt.state = hrp_pkg::ST_MIN;
                    end
                    hrp_pkg::ST_MIN, hrp_pkg::ST_SP_END: begin
                        if (c == hrp_pkg::CH_CR) begin
                            o_nxt.state = hrp_pkg::ST_RL_CR;
                        end else if (c == hrp_pkg::CH_LF) begin
                            o_nxt.state = hrp_pkg::ST_HD_START;
                        end else if (c == hrp_pkg::CH_SP) begin
                            o_nxt.state = hrp_pkg::ST_SP_END;
                        end else begin
                            o_nxt.minor = version_acc(cur.minor, c);
                        end
                    end
                    hrp_pkg::ST_RL_CR: o_nxt.state = hrp_pkg::ST_HD_START;
                    hrp_pkg::ST_HD_START: begin
                        if (c == hrp_pkg::CH_CR) begin
                            o_nxt.state = hrp_pkg::ST_HD_CRLFCR;
                        end else if (c != hrp_pkg::CH_LF) begin
                            o_nxt.spans[0] = pos;
                            o_nxt.state    = hrp_pkg::ST_KEY;
                        end
                    end
                    hrp_pkg::ST_KEY: begin
                        if (c == hrp_pkg::CH_SP) begin
                            o_nxt.spans[1] = pos;
                            o_nxt.state    = hrp_pkg::ST_SP_COLON;
                        end else if (c == hrp_pkg::CH_COLON) begin
                            o_nxt.spans[1] = pos;
                            o_nxt.state    = hrp_pkg::ST_SP_VALUE;
                        end
                    end
                    hrp_pkg::ST_SP_COLON: begin
                        if (c == hrp_pkg::CH_COLON) o_nxt.state = hrp_pkg::ST_SP_VALUE;
                    end
                    hrp_pkg::ST_SP_VALUE: begin
                        if (c != hrp_pkg::CH_SP) begin
                            o_nxt.spans[2] = pos;
                            o_nxt.state    = hrp_pkg::ST_VALUE;
                        end
                    end
                    hrp_pkg::ST_VALUE: begin
                        if (c == hrp_pkg::CH_CR) begin
                            o_nxt.spans[3] = pos;
                            o_nxt.state    = hrp_pkg::ST_HD_CR;
                        end else if (c == hrp_pkg::CH_LF) begin
                            o_nxt.spans[3] = pos;
                            o_nxt.state    = hrp_pkg::ST_HD_CRLF;
                        end
                    end
                    hrp_pkg::ST_HD_CR: o_nxt.state = hrp_pkg::ST_HD_CRLF;
                    hrp_pkg::ST_HD_CRLF: begin
                        if (c == hrp_pkg::CH_CR) begin
                            o_nxt.state = hrp_pkg::ST_HD_CRLFCR;
                        end else begin
                            o_nxt.spans[0] = pos;
                            o_nxt.state    = hrp_pkg::ST_KEY;
                        end
                    end
                    hrp_pkg::ST_HD_CRLFCR: o_nxt.state = hrp_pkg::ST_RL_START;
                    default: o_nxt.state = hrp_pkg::ST_RL_START;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/hrp_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result buffer: output register plus a skid entry.
module hrp_out_buf (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push_valid,
    input  wire hrp_pkg::t_out_item i_push_item,
    output logic                   o_full,
    output logic                   o_valid,
    output hrp_pkg::t_out_item     o_item,
    input  wire                    i_stall
);

    logic               r_main_v;
    logic               r_skid_v;
    hrp_pkg::t_out_item r_main;
    hrp_pkg::t_out_item r_skid;
    logic               pop;

    assign pop     = r_main_v && !i_stall;
    assign o_full  = r_skid_v;
    assign o_valid = r_main_v;
    assign o_item  = r_main;

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_main_v || pop) begin
            r_main_v <= i_push_valid;
        end else if (i_push_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (!r_main_v || pop) begin
            if (i_push_valid) begin
                r_main <= i_push_item;
            end
        end else if (i_push_valid) begin
            r_skid <= i_push_item;
        end
    end

    // skid entry only fills behind a waiting output entry
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid entry valid with empty output entry");

    // no push is offered while the buffer reports full
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_push_valid)
        else $error("result pushed into full buffer");

    // a stalled skid entry moves to the output once the stall lifts
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && pop) |=> (r_main_v && !r_skid_v))
        else $error("skid entry not drained");

endmodule

`default_nettype wire

### hw/rtl/http_request_head_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none

// HTTP/1.x request head parser.
// Input channel: one byte of the request head per item (data_byte, restart),
// handshaked by i_in_valid / o_in_stall. restart set on an item clears all
// parse state and the byte offset before that byte is parsed.
// Output channel: at most one event per input item (request line, header,
// end of head, or an error), handshaked by o_out_valid / i_out_stall.
// Each byte is parsed in the cycle it is accepted; its event is registered
// in the result buffer's output entry, or in its skid entry under stall.
// Throughput is one byte per cycle while o_in_stall is low.
// A two-entry result buffer sits on the output: the block keeps accepting
// bytes while one event waits under stall, and raises o_in_stall only when
// a second event is held behind it.
// After an error the parser drops every byte, without output, until an item
// with restart set arrives.
// Reset (synchronous, active low) puts the parser at the start of a request
// line with offset zero and empties the result buffer.
module http_request_head_parser_top (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  wire hrp_pkg::t_in_item  i_in_item,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output hrp_pkg::t_out_item      o_out_item,
    input  wire                     i_out_stall
);

    hrp_pkg::t_parse_regs r_regs;
    hrp_pkg::t_parse_regs n_regs;
    logic                 ev_valid;
    hrp_pkg::t_out_item   ev;
    logic                 buf_full;
    logic                 accept;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    hrp_step u_step (
        .i_cur      (r_regs),
        .i_item     (i_in_item),
        .o_nxt      (n_regs),
        .o_ev_valid (ev_valid),
        .o_ev       (ev)
    );

    // Parser context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= hrp_pkg::REGS_RESET;
        end else if (accept) begin
            r_regs <= n_regs;
        end
    end

    hrp_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (accept && ev_valid),
        .i_push_item  (ev),
        .o_full       (buf_full),
        .o_valid      (o_out_valid),
        .o_item       (o_out_item),
        .i_stall      (i_out_stall)
    );

    // halted parser neither emits nor counts bytes
    a_halted_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_regs.halted && !i_in_item.restart) |->
        (!ev_valid && n_regs.offset == r_regs.offset))
        else $error("halted parser advanced");

    // offset never goes back without restart
    a_offset_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_in_item.restart) |=> (r_regs.offset >= $past(r_regs.offset)))
        else $error("byte offset decreased");

    // an error event leaves the parser halted
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ev_valid && (ev.event_kind == hrp_pkg::EV_BAD_METHOD ||
         ev.event_kind == hrp_pkg::EV_BAD_REQUEST ||
         ev.event_kind == hrp_pkg::EV_BAD_HEADER)) |=> r_regs.halted)
        else $error("error event without halt");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hrp_pkg::*;

    localparam int unsigned VERSION_TOP = (1 << VERSION_BITS) - 1;

    // One row of stimulus; fixed rows carry an event typed in by hand
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       fixed;
        t_out_item  res;
    } t_stim_row;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_CLOGGED} t_rx_mode;

    // Directed rows: a minimal GET head with a blank line, then bad-method and bad-request errors
    localparam t_stim_row DIRECTED [27] = '{
        '{CH_LF, 1'b1, 1'b0, '0},                // restart; leading LF skipped
        '{"G",   1'b0, 1'b0, '0},
        '{"E",   1'b0, 1'b0, '0},
        '{"T",   1'b0, 1'b0, '0},
        '{CH_SP, 1'b0, 1'b0, '0},
        '{"/",   1'b0, 1'b0, '0},
        '{CH_SP, 1'b0, 1'b0, '0},
        '{"H",   1'b0, 1'b0, '0},
        '{"T",   1'b0, 1'b0, '0},
        '{"T",   1'b0, 1'b0, '0},
        '{"P",   1'b0, 1'b0, '0},
        '{"/",   1'b0, 1'b0, '0},
        '{"1",   1'b0, 1'b0, '0},
        '{".",   1'b0, 1'b0, '0},
        '{"1",   1'b0, 1'b0, '0},
        '{CH_CR, 1'b0, 1'b0, '0},
        '{CH_LF, 1'b0, 1'b1,
          '{EV_LINE, METH_GET, 8'd1, 8'd1, 16'd1, 16'd4, 16'd5, 16'd6}},
        '{CH_CR, 1'b0, 1'b0, '0},                // blank line where a key would start
        '{CH_LF, 1'b0, 1'b1, '{EV_END, 2'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
        '{8'h00, 1'b1, 1'b1,
          '{EV_BAD_METHOD, 2'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
        '{8'hFF, 1'b0, 1'b0, '0},                // halted: dropped
        '{"_",   1'b1, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1,
          '{EV_BAD_METHOD, 2'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
        '{"G",   1'b1, 1'b0, '0},
        '{CH_SP, 1'b0, 1'b0, '0},
        '{CH_SP, 1'b0, 1'b0, '0},
        '{"x",   1'b0, 1'b1,
          '{EV_BAD_REQUEST, 2'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}}
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in_item   = '0;
    logic       i_out_stall = 1'b0;
    wire        o_in_stall;
    wire        o_out_valid;
    t_out_item  o_out_item;

    // Parser shadow state
    t_state                     p_state;
    logic                       p_halted;
    logic [OFFSET_BITS-1:0]     p_offset;
    logic [31:0]                p_word;
    logic [OFFSET_BITS-1:0]     p_marks [4];
    logic [VERSION_BITS-1:0]    p_major;
    logic [VERSION_BITS-1:0]    p_minor;
    logic [1:0]                 p_method;

    t_stim_row  stim_q [$];
    t_out_item  awaited_events [$];
    logic [7:0] head_bytes [$];
    t_stim_row  drv_row = '0;
    int         burst_left = 0;
    int         mismatches = 0;
    t_rx_mode   rx_mode = RX_OPEN;
    int         rx_left = 0;
    logic [7:0] rx_mask = 8'h01;

    always #10 i_clk = ~i_clk;

    http_request_head_parser_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    function automatic bit is_method_char(logic [7:0] c);
        return (c >= CH_A && c <= CH_Z) || c == CH_UNDER;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Decimal accumulate, sticking at the top value
    function automatic logic [VERSION_BITS-1:0] version_step(logic [VERSION_BITS-1:0] v,
                                                             logic [7:0] c);
        int n;
        n = 10 * int'(v) + int'(c) - int'(CH_ZERO);
        return (n > VERSION_TOP) ? VERSION_TOP[VERSION_BITS-1:0] : n[VERSION_BITS-1:0];
    endfunction

    task automatic clear_parser();
        p_state  = ST_RL_START;
        p_halted = 1'b0;
        p_offset = '0;
        p_word   = '0;
        foreach (p_marks[i]) p_marks[i] = '0;
        p_major  = '0;
        p_minor  = '0;
        p_method = METH_UNKNOWN;
    endtask

    // Advance the shadow parser by one byte; emit is set when an event results
    task automatic parse_byte(input t_in_item it, output bit emit, output t_out_item ev);
        logic [7:0]             c;
        logic [OFFSET_BITS-1:0] pos;
        logic [OFFSET_BITS-1:0] len;
        logic [2:0]             err;
        bit                     bad;
        bit                     line_done;
        bit                     hdr_done;
        c         = it.data_byte;
        emit      = 1'b0;
        ev        = '0;
        bad       = 1'b0;
        err       = EV_BAD_REQUEST;
        line_done = 1'b0;
        hdr_done  = 1'b0;
        if (it.restart) clear_parser();
        if (p_halted) return;

        pos = p_offset;
        if (p_offset != OFFSET_MAX) p_offset = p_offset + 1'b1;

        case (p_state)
            ST_RL_START: begin
                if (c != CH_CR && c != CH_LF) begin
                    if (!is_method_char(c)) begin
                        bad = 1'b1;
                        err = EV_BAD_METHOD;
                    end else begin
                        p_marks[0] = pos;
                        p_word     = {24'h0, c};
                        p_state    = ST_METHOD;
                    end
                end
            end
            ST_METHOD: begin
                if (c == CH_SP) begin
                    p_marks[1] = pos;
                    len = pos - p_marks[0];
                    if (len == 3 && p_word[23:0] == WORD_GET) p_method = METH_GET;
                    else if (len == 4 && p_word == WORD_POST) p_method = METH_POST;
                    else if (len == 4 && p_word == WORD_HEAD) p_method = METH_HEAD;
                    else p_method = METH_UNKNOWN;
                    p_state = ST_SP_URI;
                end else if (!is_method_char(c)) begin
                    bad = 1'b1;
                    err = EV_BAD_METHOD;
                end else begin
                    p_word = {p_word[23:0], c};
                end
            end
            ST_SP_URI: begin
                if (c == CH_SLASH) begin
                    p_marks[2] = pos;
                    p_state    = ST_URI;
                end else if (c != CH_SP) begin
                    bad = 1'b1;
                end
            end
            ST_URI: begin
                if (c == CH_SP) begin
                    p_marks[3] = pos;
                    p_state    = ST_PROTO;
                end
            end
            ST_PROTO: begin
                if (c != CH_SP) begin
                    if (c != CH_H) bad = 1'b1;
                    else p_state = ST_P_H;
                end
            end
            ST_P_H: begin
                if (c != CH_T) bad = 1'b1;
                else p_state = ST_P_HT;
            end
            ST_P_HT: begin
                if (c != CH_T) bad = 1'b1;
                else p_state = ST_P_HTT;
            end
            ST_P_HTT: begin
                if (c != CH_P) bad = 1'b1;
                else p_state = ST_P_HTTP;
            end
            ST_P_HTTP: begin
                if (c != CH_SLASH) bad = 1'b1;
                else p_state = ST_MAJ_FIRST;
            end
            ST_MAJ_FIRST: begin
                if (c < CH_ONE || c > CH_NINE) begin
                    bad = 1'b1;
                end else begin
                    p_major = version_step('0, c);
                    p_state = ST_MAJ;
                end
            end
            ST_MAJ: begin
                if (c == CH_DOT) p_state = ST_MIN_FIRST;
                else if (!is_digit(c)) bad = 1'b1;
                else p_major = version_step(p_major, c);
            end
            ST_MIN_FIRST: begin
                if (!is_digit(c)) begin
                    bad = 1'b1;
                end else begin
                    p_minor = version_step('0, c);
                    p_state = ST_MIN;
                end
            end
            ST_MIN, ST_SP_END: begin
                if (c == CH_CR) p_state = ST_RL_CR;
                else if (c == CH_LF) line_done = 1'b1;
                else if (c == CH_SP) p_state = ST_SP_END;
                else if (p_state == ST_SP_END || !is_digit(c)) bad = 1'b1;
                else p_minor = version_step(p_minor, c);
            end
            ST_RL_CR: begin
                if (c != CH_LF) bad = 1'b1;
                else line_done = 1'b1;
            end
            ST_HD_START: begin
                if (c == CH_CR) begin
                    p_state = ST_HD_CRLFCR;
                end else if (c != CH_LF) begin
                    p_marks[0] = pos;
                    p_state    = ST_KEY;
                end
            end
            ST_KEY: begin
                if (c == CH_SP) begin
                    p_marks[1] = pos;
                    p_state    = ST_SP_COLON;
                end else if (c == CH_COLON) begin
                    p_marks[1] = pos;
                    p_state    = ST_SP_VALUE;
                end
            end
            ST_SP_COLON: begin
                if (c == CH_COLON) begin
                    p_state = ST_SP_VALUE;
                end else if (c != CH_SP) begin
                    bad = 1'b1;
                    err = EV_BAD_HEADER;
                end
            end
            ST_SP_VALUE: begin
                if (c != CH_SP) begin
                    p_marks[2] = pos;
                    p_state    = ST_VALUE;
                end
            end
            ST_VALUE: begin
                if (c == CH_CR) begin
                    p_marks[3] = pos;
                    p_state    = ST_HD_CR;
                end else if (c == CH_LF) begin
                    p_marks[3] = pos;
                    hdr_done   = 1'b1;
                end
            end
            ST_HD_CR: begin
                if (c != CH_LF) begin
                    bad = 1'b1;
                    err = EV_BAD_HEADER;
                end else begin
                    hdr_done = 1'b1;
                end
            end
            ST_HD_CRLF: begin
                if (c == CH_CR) begin
                    p_state = ST_HD_CRLFCR;
                end else begin
                    p_marks[0] = pos;
                    p_state    = ST_KEY;
                end
            end
            default: begin
                // second half of the blank line
                if (c != CH_LF) begin
                    bad = 1'b1;
                    err = EV_BAD_HEADER;
                end else begin
                    emit          = 1'b1;
                    ev.event_kind = EV_END;
                    p_state       = ST_RL_START;
                end
            end
        endcase

        if (bad) begin
            p_halted      = 1'b1;
            emit          = 1'b1;
            ev.event_kind = err;
        end else if (line_done || hdr_done) begin
            emit                 = 1'b1;
            ev.event_kind        = line_done ? EV_LINE : EV_HEADER;
            ev.first_span_start  = 16'(p_marks[0]);
            ev.first_span_end    = 16'(p_marks[1]);
            ev.second_span_start = 16'(p_marks[2]);
            ev.second_span_end   = 16'(p_marks[3]);
            if (line_done) begin
                ev.method_code   = p_method;
                ev.version_major = 8'(p_major);
                ev.version_minor = 8'(p_minor);
                p_state          = ST_HD_START;
            end else begin
                p_state          = ST_HD_CRLF;
            end
        end
    endtask

    task automatic check_event(input t_out_item want, input t_out_item got);
        bit bad;
        bad = 1'b0;
        if (got.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
            bad = 1'b1;
        end
        if (got.method_code !== want.method_code) begin
            $error("method_code: expected %0d, got %0d", want.method_code, got.method_code);
            bad = 1'b1;
        end
        if (got.version_major !== want.version_major) begin
            $error("version_major: expected %0d, got %0d",
                   want.version_major, got.version_major);
            bad = 1'b1;
        end
        if (got.version_minor !== want.version_minor) begin
            $error("version_minor: expected %0d, got %0d",
                   want.version_minor, got.version_minor);
            bad = 1'b1;
        end
        if (got.first_span_start !== want.first_span_start) begin
            $error("first_span_start: expected %0d, got %0d",
                   want.first_span_start, got.first_span_start);
            bad = 1'b1;
        end
        if (got.first_span_end !== want.first_span_end) begin
            $error("first_span_end: expected %0d, got %0d",
                   want.first_span_end, got.first_span_end);
            bad = 1'b1;
        end
        if (got.second_span_start !== want.second_span_start) begin
            $error("second_span_start: expected %0d, got %0d",
                   want.second_span_start, got.second_span_start);
            bad = 1'b1;
        end
        if (got.second_span_end !== want.second_span_end) begin
            $error("second_span_end: expected %0d, got %0d",
                   want.second_span_end, got.second_span_end);
            bad = 1'b1;
        end
        if (bad) mismatches++;
    endtask

    // Random byte that avoids up to three values
    function automatic logic [7:0] pick_byte(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == a || v == b || v == c);
        return v;
    endfunction

    task automatic queue_item(input logic [7:0] data, input bit rst);
        t_stim_row r;
        r = '{data, rst, 1'b0, '0};
        stim_q.push_back(r);
    endtask

    task automatic put_byte(input logic [7:0] c);
        head_bytes.push_back(c);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) head_bytes.push_back(s[i]);
    endtask

    task automatic flush_head(input bit rst);
        foreach (head_bytes[i]) queue_item(head_bytes[i], rst && i == 0);
        head_bytes.delete();
    endtask

    // Build one request head with random content; now and then break it and cut it short
    task automatic gen_request(input bit rst, output bit broke);
        string letters;
        int    headers;
        int    cut;
        int    v;
        letters = "GETPOSHAD";
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
            put_byte($urandom_range(0, 1) ? CH_CR : CH_LF);

        // method
        case ($urandom_range(0, 6))
            0: put_text("GET");
            1: put_text("HEAD");
            2: put_text("POST");
            3: begin
                case ($urandom_range(0, 5))
                    0: put_text("GE");
                    1: put_text("GETS");
                    2: put_text("HEA");
                    3: put_text("HEADS");
                    4: put_text("POS");
                    default: put_text("PUT");
                endcase
            end
            4, 5: begin
                repeat ($urandom_range(1, 6)) begin
                    v = $urandom_range(0, 26);
                    put_byte((v == 26) ? CH_UNDER : 8'(CH_A + v));
                end
            end
            default: repeat ($urandom_range(3, 4)) put_byte(letters[$urandom_range(0, 8)]);
        endcase

        // URI and protocol
        repeat ($urandom_range(1, 2)) put_byte(CH_SP);
        put_byte(CH_SLASH);
        repeat ($urandom_range(0, 6)) put_byte(pick_byte(CH_SP, CH_SP, CH_SP));
        repeat ($urandom_range(1, 2)) put_byte(CH_SP);
        put_text("HTTP/");
        put_byte(8'(CH_ONE + $urandom_range(0, 8)));
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2))
            put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        put_byte(CH_DOT);
        put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2))
            put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) put_byte(CH_SP);
        if ($urandom_range(0, 3) == 0) begin
            put_byte(CH_LF);
        end else begin
            put_byte(CH_CR);
            put_byte(CH_LF);
        end

        // headers, then the blank line
        headers = $urandom_range(0, 3);
        if (headers != 0 && $urandom_range(0, 5) == 0) put_byte(CH_LF);
        repeat (headers) begin
            put_byte(pick_byte(CH_CR, CH_LF, CH_LF));
            repeat ($urandom_range(0, 4)) put_byte(pick_byte(CH_SP, CH_COLON, CH_COLON));
            repeat ($urandom_range(0, 2)) put_byte(CH_SP);
            put_byte(CH_COLON);
            repeat ($urandom_range(0, 2)) put_byte(CH_SP);
            put_byte(pick_byte(CH_SP, CH_SP, CH_SP));
            repeat ($urandom_range(0, 6)) put_byte(pick_byte(CH_CR, CH_LF, CH_LF));
            if ($urandom_range(0, 3) != 0) put_byte(CH_CR);
            put_byte(CH_LF);
        end
        put_byte(CH_CR);
        put_byte(CH_LF);

        // corrupt one byte by overwrite or insertion, drop most of what follows
        broke = ($urandom_range(0, 3) == 0);
        if (broke) begin
            cut = $urandom_range(0, head_bytes.size() - 1);
            if ($urandom_range(0, 1)) head_bytes[cut] = 8'($urandom_range(0, 255));
            else head_bytes.insert(cut, 8'($urandom_range(0, 255)));
            cut = cut + 1 + $urandom_range(0, 3);
            while (head_bytes.size() > cut) void'(head_bytes.pop_back());
        end
        flush_head(rst);
    endtask

    // Drive queued rows in bursts with idle gaps between them
    task automatic send_rows();
        t_stim_row r;
        while (stim_q.size() != 0) begin
            r = stim_q.pop_front();
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 24);
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left--;
            i_in_valid <= 1'b1;
            i_in_item  <= '{data_byte: r.data, restart: r.restart};
            drv_row    <= r;
            do @(posedge i_clk); while (o_in_stall);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic drain_events();
        do @(posedge i_clk); while (awaited_events.size() != 0);
    endtask

    // Shadow parser on each accepted item, then check each accepted event
    always @(posedge i_clk) begin
        bit        emit;
        t_out_item ev;
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_in_item, emit, ev);
                if (drv_row.fixed) awaited_events.push_back(drv_row.res);
                else if (emit) awaited_events.push_back(ev);
            end
            if (o_out_valid && !i_out_stall) begin
                if (awaited_events.size() == 0) begin
                    $error("event with none awaited: event_kind %0d", o_out_item.event_kind);
                    mismatches++;
                end else begin
                    check_event(awaited_events.pop_front(), o_out_item);
                end
            end
        end
    end

    // Receiver back-pressure: open, coin toss, rotating mask, or mostly stalled
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 256);
            rx_mask = 8'($urandom_range(1, 255));
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:    i_out_stall <= 1'b0;
            RX_COIN:    i_out_stall <= 1'($urandom_range(0, 1));
            RX_PATTERN: begin
                i_out_stall <= rx_mask[0];
                rx_mask = {rx_mask[0], rx_mask[7:1]};
            end
            RX_CLOGGED: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    initial begin
        bit broke;
        bit need_restart;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);
        send_rows();
        drain_events();

        // one long URI, then a single header and the blank line
        put_text("GET /");
        repeat (120) put_byte(pick_byte(CH_SP, CH_SP, CH_SP));
        put_text(" HTTP/1.0");
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_text("K: v");
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_byte(CH_CR);
        put_byte(CH_LF);
        flush_head(1'b1);
        send_rows();
        drain_events();

        // random heads, mostly well formed, mixed with short bursts of noise
        need_restart = 1'b0;
        while (stim_q.size() < 1480) begin
            if ($urandom_range(0, 99) < 6) begin
                repeat ($urandom_range(1, 4))
                    queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                need_restart = 1'b1;
            end else begin
                gen_request(need_restart || $urandom_range(0, 9) == 0, broke);
                need_restart = broke;
            end
        end
        send_rows();
        drain_events();
        repeat (16) @(posedge i_clk);

        if (mismatches == 0 && awaited_events.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### http_request_head_parser_top.f
hw/rtl/hrp_pkg.sv
hw/rtl/hrp_step.sv
hw/rtl/hrp_out_buf.sv
hw/rtl/http_request_head_parser_top.sv
tb/tb_top.sv
